/* hdl/twi_seq_pkg.sv */
// Shared definitions for the two-wire master transaction sequencer.
// Command, action and bus status codes, widths and the default buffer depth.
// No dependencies.
`timescale 1ns / 1ps

package twi_seq_pkg;

	localparam int BufferDepthDefault = 128;
	localparam int ByteW  = 8;
	localparam int IndexW = 7;
	localparam int InDataW  = 40;
	localparam int OutDataW = 32;

	localparam logic [ByteW-1:0] StatusMask = 8'hFC;

	// Host commands carried on tuser of the input stream
	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_START = 2'd1,
		CMD_EVENT = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	// Requests handed to the bus engine, on tuser of the output stream
	typedef enum logic [2:0] {
		ACT_NONE    = 3'd0,
		ACT_START   = 3'd1,
		ACT_TX      = 3'd2,
		ACT_RX_ACK  = 3'd3,
		ACT_RX_NACK = 3'd4,
		ACT_STOP    = 3'd5,
		ACT_RESTART = 3'd6,
		ACT_DISABLE = 3'd7
	} action_t;

	// Masked bus status codes
	localparam logic [ByteW-1:0] StStart     = 8'h08;
	localparam logic [ByteW-1:0] StRepStart  = 8'h10;
	localparam logic [ByteW-1:0] StAddrWAck  = 8'h18;
	localparam logic [ByteW-1:0] StDataWAck  = 8'h28;
	localparam logic [ByteW-1:0] StArbLost   = 8'h38;
	localparam logic [ByteW-1:0] StAddrRAck  = 8'h40;
	localparam logic [ByteW-1:0] StDataRAck  = 8'h50;
	localparam logic [ByteW-1:0] StDataRNack = 8'h58;

endpackage

/* hdl/twi_master_transaction_sequencer_core.sv */
// Top level of the two-wire master transaction sequencer.
// Uses twi_seq_pkg for codes and twi_seq_ram for the message buffer.
`timescale 1ns / 1ps

// One command is taken per clock while stage 1 can move on. The command is
// decoded and the transaction registers updated in the cycle of the
// transfer, the message buffer is read through its registered port in the
// same cycle, and the result passes from stage 1 into an output register
// once that register is free or drained. The buffer needs no clearing after
// reset; bytes not yet written read as undefined.
// Loads, reads and stores at positions at or beyond BUFFER_DEPTH are
// dropped or read as zero.
module twi_master_transaction_sequencer_core #(
	parameter int BUFFER_DEPTH = twi_seq_pkg::BufferDepthDefault
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// index[6:0], data[14:7], dev_address[21:15], read_not_write[22],
	// length[29:23], bus_status[37:30], zero fill [39:38]
	input  logic [twi_seq_pkg::InDataW-1:0]   s_tdata,
	// cmd[1:0]
	input  logic [1:0]                        s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// tx_byte[7:0], read_data[15:8], busy_res[16], done_ok[17], failed[18],
	// fault_status[26:19], zero fill [31:27]
	output logic [twi_seq_pkg::OutDataW-1:0]  m_tdata,
	// action[2:0]
	output logic [2:0]                        m_tuser
);

	localparam int AW = $clog2(BUFFER_DEPTH);
	localparam int BW = twi_seq_pkg::ByteW;
	localparam int IW = twi_seq_pkg::IndexW;

	// Input fields
	logic [IW-1:0] in_index;
	logic [BW-1:0] in_data;
	logic [IW-1:0] in_dev;
	logic          in_rnw;
	logic [IW-1:0] in_len;
	logic [BW-1:0] in_status;
	twi_seq_pkg::cmd_t in_cmd;

	assign in_index  = s_tdata[6:0];
	assign in_data   = s_tdata[14:7];
	assign in_dev    = s_tdata[21:15];
	assign in_rnw    = s_tdata[22];
	assign in_len    = s_tdata[29:23];
	assign in_status = s_tdata[37:30];
	assign in_cmd    = twi_seq_pkg::cmd_t'(s_tuser);

	// Transaction registers
	logic [IW-1:0] ptr_q, len_q;
	logic          success_q, busy_q, fault_valid_q;
	logic [BW-1:0] fault_q;

	// Stage 1 (buffer read in flight) and output register
	logic                    v_s1;
	twi_seq_pkg::action_t    action_s1;
	logic                    tx_sel_s1, rd_sel_s1, pos_ok_s1;
	logic                    busy_s1, done_s1, failed_s1;
	logic [BW-1:0]           fault_s1;
	logic                    out_valid_q;
	twi_seq_pkg::action_t    out_action_q;
	logic [BW-1:0]           out_tx_q, out_rd_q, out_fault_q;
	logic                    out_busy_q, out_done_q, out_failed_q;

	logic accept, advance;

	// Handshake: stage 1 moves on whenever the output register is free or drained
	assign advance  = v_s1 && (!out_valid_q || m_tready);
	assign s_tready = !v_s1 || advance;
	assign accept   = s_tvalid && s_tready;

	// Next-state decode
	logic [IW-1:0]        ptr_d, len_d, ptr_base, limit, mem_pos;
	logic                 success_d, busy_d, fault_valid_d;
	logic [BW-1:0]        fault_d, wr_byte, st_masked;
	logic                 we, re, tx_sel, rd_sel;
	twi_seq_pkg::action_t action_d;
	logic [AW-1:0]        waddr, raddr;
	logic [BW-1:0]        rdata;
	logic                 pos_ok;

	assign st_masked = in_status & twi_seq_pkg::StatusMask;
	assign limit     = (len_q != '0) ? len_q - IW'(1) : '0;
	assign ptr_base  = (st_masked == twi_seq_pkg::StStart ||
		st_masked == twi_seq_pkg::StRepStart) ? '0 : ptr_q;

	always_comb begin
		ptr_d         = ptr_q;
		len_d         = len_q;
		success_d     = success_q;
		busy_d        = busy_q;
		fault_valid_d = fault_valid_q;
		fault_d       = fault_q;
		action_d      = twi_seq_pkg::ACT_NONE;
		we            = 1'b0;
		re            = 1'b0;
		tx_sel        = 1'b0;
		rd_sel        = 1'b0;
		mem_pos       = in_index;
		wr_byte       = in_data;
		case (in_cmd)
			twi_seq_pkg::CMD_LOAD: begin
				we = 1'b1;
			end
			twi_seq_pkg::CMD_START: begin
				if (!busy_q) begin
					we            = 1'b1;
					mem_pos       = '0;
					wr_byte       = {in_dev, in_rnw};
					len_d         = in_len;
					success_d     = 1'b0;
					fault_d       = '0;
					fault_valid_d = 1'b0;
					busy_d        = 1'b1;
					action_d      = twi_seq_pkg::ACT_START;
				end
			end
			twi_seq_pkg::CMD_EVENT: begin
				if (busy_q) begin
					mem_pos = ptr_q;
					case (st_masked)
						twi_seq_pkg::StStart, twi_seq_pkg::StRepStart,
						twi_seq_pkg::StAddrWAck, twi_seq_pkg::StDataWAck: begin
							// send the next byte, or stop when all are out
							mem_pos = ptr_base;
							if (ptr_base < len_q) begin
								re       = 1'b1;
								tx_sel   = 1'b1;
								ptr_d    = ptr_base + IW'(1);
								action_d = twi_seq_pkg::ACT_TX;
							end else begin
								ptr_d     = ptr_base;
								success_d = 1'b1;
								busy_d    = 1'b0;
								action_d  = twi_seq_pkg::ACT_STOP;
							end
						end
						twi_seq_pkg::StDataRAck: begin
							we       = 1'b1;
							ptr_d    = ptr_q + IW'(1);
							action_d = (ptr_d < limit) ? twi_seq_pkg::ACT_RX_ACK
								: twi_seq_pkg::ACT_RX_NACK;
						end
						twi_seq_pkg::StAddrRAck: begin
							action_d = (ptr_q < limit) ? twi_seq_pkg::ACT_RX_ACK
								: twi_seq_pkg::ACT_RX_NACK;
						end
						twi_seq_pkg::StDataRNack: begin
							we        = 1'b1;
							success_d = 1'b1;
							busy_d    = 1'b0;
							action_d  = twi_seq_pkg::ACT_STOP;
						end
						twi_seq_pkg::StArbLost: begin
							action_d = twi_seq_pkg::ACT_RESTART;
						end
						default: begin
							// unexpected status: record the raw byte and drop out
							fault_d       = in_status;
							fault_valid_d = 1'b1;
							busy_d        = 1'b0;
							action_d      = twi_seq_pkg::ACT_DISABLE;
						end
					endcase
				end
			end
			default: begin
				re     = 1'b1;
				rd_sel = 1'b1;
			end
		endcase
	end

	// Positions past the end of the buffer are dropped on write, zero on read
	assign pos_ok = (int'(mem_pos) < BUFFER_DEPTH);
	assign waddr  = AW'(mem_pos);
	assign raddr  = AW'(mem_pos);

	twi_seq_ram #(
		.WIDTH(BW),
		.DEPTH(BUFFER_DEPTH)
	) u_buffer (
		.clk  (clk),
		.we   (accept && we && pos_ok),
		.waddr(waddr),
		.wdata(wr_byte),
		.re   (accept && re),
		.raddr(raddr),
		.rdata(rdata)
	);

	// Transaction registers update on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q         <= '0;
			len_q         <= '0;
			success_q     <= 1'b0;
			busy_q        <= 1'b0;
			fault_valid_q <= 1'b0;
			fault_q       <= '0;
		end else if (accept) begin
			ptr_q         <= ptr_d;
			len_q         <= len_d;
			success_q     <= success_d;
			busy_q        <= busy_d;
			fault_valid_q <= fault_valid_d;
			fault_q       <= fault_d;
		end
	end

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (advance) begin
			v_s1 <= 1'b0;
		end
	end

	// Stage 1 payload, aligned with the buffer read data
	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1 <= action_d;
			tx_sel_s1 <= tx_sel;
			rd_sel_s1 <= rd_sel;
			pos_ok_s1 <= pos_ok;
			busy_s1   <= busy_d;
			done_s1   <= success_d;
			failed_s1 <= fault_valid_d;
			fault_s1  <= fault_d;
		end
	end

	// Output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			out_action_q <= action_s1;
			out_tx_q     <= (tx_sel_s1 && pos_ok_s1) ? rdata : '0;
			out_rd_q     <= (rd_sel_s1 && pos_ok_s1) ? rdata : '0;
			out_busy_q   <= busy_s1;
			out_done_q   <= done_s1;
			out_failed_q <= failed_s1;
			out_fault_q  <= fault_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_action_q;
	assign m_tdata  = {5'd0, out_fault_q, out_failed_q, out_done_q, out_busy_q,
		out_rd_q, out_tx_q};

endmodule

/* hdl/twi_seq_ram.sv */
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module twi_seq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* sim/twi_seq_checker.sv */
// Scoreboard for the two-wire master transaction sequencer testbench.
// Watches both stream channels, predicts every result and compares it.
// Depends on twi_seq_pkg.
`timescale 1ns / 1ps

import twi_seq_pkg::*;

module twi_seq_checker #(
	parameter int BUFFER_DEPTH = BufferDepthDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_tready,
	// index[6:0], data[14:7], dev_address[21:15], read_not_write[22],
	// length[29:23], bus_status[37:30], zero fill [39:38]
	input  logic [InDataW-1:0]  s_tdata,
	// cmd[1:0]
	input  logic [1:0]          s_tuser,
	input  logic                m_tvalid,
	input  logic                m_tready,
	// tx_byte[7:0], read_data[15:8], busy_res[16], done_ok[17], failed[18],
	// fault_status[26:19], zero fill [31:27]
	input  logic [OutDataW-1:0] m_tdata,
	// action[2:0]
	input  logic [2:0]          m_tuser,
	output int                  fail_count,
	output int                  outstanding,
	output int                  results_checked,
	output int                  clean_stops,
	output int                  faults_seen
);

	typedef struct packed {
		action_t          action;
		logic [ByteW-1:0] tx_byte;
		logic [ByteW-1:0] read_data;
		logic             busy;
		logic             done_ok;
		logic             failed;
		logic [ByteW-1:0] fault_status;
	} seq_result_t;

	// Shadow of the sequencer state
	logic [ByteW-1:0]  msg_buf [0:BUFFER_DEPTH-1];
	logic [IndexW-1:0] byte_ptr;
	logic [IndexW-1:0] xfer_len;
	logic              success;
	logic              busy;
	logic              fault_valid;
	logic [ByteW-1:0]  fault_code;

	seq_result_t pending_results [$];

	// Positions past the buffer read as zero and drop stores
	function automatic logic [ByteW-1:0] buffer_byte(input int unsigned pos);
		return (pos < BUFFER_DEPTH) ? msg_buf[pos] : '0;
	endfunction

	task automatic store_byte(input int unsigned pos, input logic [ByteW-1:0] value);
		if (pos < BUFFER_DEPTH)
			msg_buf[pos] = value;
	endtask

	// Next byte out, or a stop once the count is reached
	task automatic send_next(output action_t act, output logic [ByteW-1:0] tx);
		tx = '0;
		if (byte_ptr < xfer_len) begin
			tx = buffer_byte(byte_ptr);
			byte_ptr = byte_ptr + 1'b1;
			act = ACT_TX;
		end else begin
			success = 1'b1;
			busy = 1'b0;
			act = ACT_STOP;
		end
	endtask

	// NACK on the last byte; a zero length saturates the limit at zero
	function automatic action_t rx_answer();
		logic [IndexW-1:0] last;
		last = (xfer_len != '0) ? xfer_len - 1'b1 : '0;
		return (byte_ptr < last) ? ACT_RX_ACK : ACT_RX_NACK;
	endfunction

	task automatic predict(input cmd_t op, input logic [InDataW-1:0] f,
			output seq_result_t r);
		logic [IndexW-1:0] idx;
		logic [ByteW-1:0]  data;
		logic [6:0]        dev;
		logic              rnw;
		logic [IndexW-1:0] len;
		logic [ByteW-1:0]  status;
		action_t           act;
		logic [ByteW-1:0]  tx;
		{status, len, rnw, dev, data, idx} = f[37:0];
		r = '0;
		r.action = ACT_NONE;
		case (op)
			CMD_LOAD: store_byte(idx, data);
			CMD_START: begin
				if (!busy) begin
					store_byte(0, {dev, rnw});
					xfer_len = len;
					success = 1'b0;
					fault_code = '0;
					fault_valid = 1'b0;
					busy = 1'b1;
					r.action = ACT_START;
				end
			end
			CMD_EVENT: begin
				// events are ignored while no transaction is busy
				if (busy) begin
					case (status & StatusMask)
						StStart, StRepStart: begin
							byte_ptr = '0;
							send_next(act, tx);
							r.action = act;
							r.tx_byte = tx;
						end
						StAddrWAck, StDataWAck: begin
							send_next(act, tx);
							r.action = act;
							r.tx_byte = tx;
						end
						StDataRAck: begin
							store_byte(byte_ptr, data);
							byte_ptr = byte_ptr + 1'b1;
							r.action = rx_answer();
						end
						StAddrRAck: r.action = rx_answer();
						StDataRNack: begin
							store_byte(byte_ptr, data);
							success = 1'b1;
							busy = 1'b0;
							r.action = ACT_STOP;
						end
						StArbLost: r.action = ACT_RESTART;
						default: begin
							fault_code = status;
							fault_valid = 1'b1;
							busy = 1'b0;
							r.action = ACT_DISABLE;
						end
					endcase
				end
			end
			default: r.read_data = buffer_byte(idx);
		endcase
		r.busy = busy;
		r.done_ok = success;
		r.failed = fault_valid;
		r.fault_status = fault_code;
	endtask

	task automatic check_field(input string field, input logic [ByteW-1:0] want,
			input logic [ByteW-1:0] got);
		if (got !== want) begin
			fail_count++;
			if (fail_count <= 10)
				$display("%0t: %s mismatch in result %0d: expected %02h, got %02h",
					$time, field, results_checked, want, got);
		end
	endtask

	// Results are compared before the new command is predicted
	always @(posedge clk or negedge arst_n) begin : monitor
		seq_result_t want;
		if (!arst_n) begin
			byte_ptr = '0;
			xfer_len = '0;
			success = 1'b0;
			busy = 1'b0;
			fault_valid = 1'b0;
			fault_code = '0;
			pending_results.delete();
			fail_count = 0;
			outstanding = 0;
			results_checked = 0;
			clean_stops = 0;
			faults_seen = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_checked++;
				if (pending_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: result %0d arrived with nothing expected",
							$time, results_checked);
				end else begin
					want = pending_results.pop_front();
					check_field("action", want.action, m_tuser);
					check_field("tx_byte", want.tx_byte, m_tdata[7:0]);
					check_field("read_data", want.read_data, m_tdata[15:8]);
					check_field("busy_res", want.busy, m_tdata[16]);
					check_field("done_ok", want.done_ok, m_tdata[17]);
					check_field("failed", want.failed, m_tdata[18]);
					check_field("fault_status", want.fault_status, m_tdata[26:19]);
					if (want.action == ACT_STOP)
						clean_stops++;
					if (want.action == ACT_DISABLE)
						faults_seen++;
				end
			end
			if (s_tvalid && s_tready) begin
				predict(cmd_t'(s_tuser), s_tdata, want);
				pending_results.push_back(want);
			end
			outstanding = pending_results.size();
		end
	end

endmodule

/* sim/twi_master_transaction_sequencer_core_tb.sv */
// Testbench top for the two-wire master transaction sequencer core.
// Drives directed and random command streams; twi_seq_checker does the checking.
// Depends on twi_seq_pkg, twi_seq_checker and the core RTL.
`timescale 1ns / 1ps

import twi_seq_pkg::*;

module twi_master_transaction_sequencer_core_tb;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	// index[6:0], data[14:7], dev_address[21:15], read_not_write[22],
	// length[29:23], bus_status[37:30], zero fill [39:38]
	logic [InDataW-1:0]  s_tdata = '0;
	// cmd[1:0]
	cmd_t                s_tuser = CMD_LOAD;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	// tx_byte[7:0], read_data[15:8], busy_res[16], done_ok[17], failed[18],
	// fault_status[26:19], zero fill [31:27]
	logic [OutDataW-1:0] m_tdata;
	// action[2:0]
	logic [2:0]          m_tuser;

	int fail_count;
	int outstanding;
	int results_checked;
	int clean_stops;
	int faults_seen;
	int src_idle_pct = 16;
	int sink_idle_pct = 45;
	bit long_hold = 1'b0;
	int sent = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	twi_master_transaction_sequencer_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	twi_seq_checker scoreboard (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tuser         (m_tuser),
		.fail_count      (fail_count),
		.outstanding     (outstanding),
		.results_checked (results_checked),
		.clean_stops     (clean_stops),
		.faults_seen     (faults_seen)
	);

	// Receiver: random back-pressure, plus one long hold-off to fill the block
	initial begin : receiver
		bit held;
		held = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold && !held) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (300) @(negedge clk);
			end else
				m_tready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("Verification failed");
		$finish;
	end

	function automatic logic [InDataW-1:0] pack_fields(input logic [6:0] index,
			input logic [7:0] data, input logic [6:0] dev, input logic rnw,
			input logic [6:0] len, input logic [7:0] status);
		return {2'b00, status, len, rnw, dev, data, index};
	endfunction

	// One transfer on the command stream, with random gaps before it
	task automatic issue(input cmd_t op, input logic [InDataW-1:0] fields);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= fields;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sent++;
		@(negedge clk);
	endtask

	// Fields a command does not use carry random values
	task automatic load_byte(input logic [6:0] pos, input logic [7:0] value);
		issue(CMD_LOAD, pack_fields(pos, value, 7'($urandom), 1'($urandom),
			7'($urandom), 8'($urandom)));
	endtask

	task automatic read_byte(input logic [6:0] pos);
		issue(CMD_READ, pack_fields(pos, 8'($urandom), 7'($urandom), 1'($urandom),
			7'($urandom), 8'($urandom)));
	endtask

	task automatic start_xfer(input logic [6:0] dev, input logic rnw, input logic [6:0] len);
		issue(CMD_START, pack_fields(7'($urandom), 8'($urandom), dev, rnw, len,
			8'($urandom)));
	endtask

	task automatic bus_event(input logic [7:0] status, input logic [7:0] data);
		issue(CMD_EVENT, pack_fields(7'($urandom), data, 7'($urandom), 1'($urandom),
			7'($urandom), status));
	endtask

	// Status code with random don't-care low bits
	function automatic logic [7:0] with_low(input logic [7:0] code);
		return code | 8'($urandom_range(3));
	endfunction

	// A status that none of the known codes matches after masking
	function automatic logic [7:0] fault_byte();
		logic [7:0] s;
		bit known;
		do begin
			s = 8'($urandom);
			case (s & StatusMask)
				StStart, StRepStart, StAddrWAck, StDataWAck,
				StArbLost, StAddrRAck, StDataRAck, StDataRNack: known = 1'b1;
				default: known = 1'b0;
			endcase
		end while (known);
		return s;
	endfunction

	function automatic logic [7:0] any_status();
		case ($urandom_range(9))
			0: return with_low(StStart);
			1: return with_low(StRepStart);
			2: return with_low(StAddrWAck);
			3: return with_low(StDataWAck);
			4: return with_low(StArbLost);
			5: return with_low(StAddrRAck);
			6: return with_low(StDataRAck);
			7: return with_low(StDataRNack);
			default: return 8'($urandom);
		endcase
	endfunction

	// Mostly short transactions, now and then a long one
	function automatic logic [6:0] pick_len();
		if ($urandom_range(29) == 0)
			return 7'($urandom_range(127, 64));
		return 7'($urandom_range(9));
	endfunction

	// Write: address byte, len-1 data bytes, stop; sometimes cut short by a fault
	task automatic write_txn(input logic [6:0] len);
		int cut;
		for (int i = 1; i < len; i++)
			if ($urandom_range(1))
				load_byte(7'(i), 8'($urandom));
		start_xfer(7'($urandom), 1'b0, len);
		bus_event(with_low(StStart), 8'($urandom));
		if ($urandom_range(5) == 0) begin
			bus_event(with_low(StArbLost), 8'($urandom));
			bus_event(with_low(StRepStart), 8'($urandom));
		end
		cut = ($urandom_range(7) == 0) ? $urandom_range(len) : len + 1;
		for (int k = 0; k < len; k++) begin
			if (k == cut) begin
				bus_event(fault_byte(), 8'($urandom));
				return;
			end
			// a second start mid-transfer must be ignored
			if ($urandom_range(15) == 0)
				start_xfer(7'($urandom), 1'($urandom), 7'($urandom));
			bus_event(with_low(k == 0 ? StAddrWAck : StDataWAck), 8'($urandom));
		end
	endtask

	// Read: address byte, acked bytes, a final nacked byte; extra acks run the
	// pointer round
	task automatic read_txn(input logic [6:0] len, input int extra);
		int acks;
		int cut;
		start_xfer(7'($urandom), 1'b1, len);
		bus_event(with_low(StStart), 8'($urandom));
		if (len == 0)
			return;
		if ($urandom_range(7) == 0) begin
			bus_event(with_low(StArbLost), 8'($urandom));
			bus_event(with_low(StRepStart), 8'($urandom));
		end
		bus_event(with_low(StAddrRAck), 8'($urandom));
		acks = ((len > 1) ? len - 2 : 0) + extra;
		cut = ($urandom_range(7) == 0) ? $urandom_range(acks) : acks + 1;
		for (int k = 0; k <= acks; k++) begin
			if (k == cut) begin
				bus_event(fault_byte(), 8'($urandom));
				return;
			end
			bus_event(with_low(k < acks ? StDataRAck : StDataRNack), 8'($urandom));
		end
	endtask

	// Start with random fields, random statuses, then a fault to close it
	task automatic broken_txn();
		start_xfer(7'($urandom), 1'($urandom), 7'($urandom));
		repeat ($urandom_range(6, 1))
			bus_event(any_status(), 8'($urandom));
		bus_event(fault_byte(), 8'($urandom));
	endtask

	task automatic run_phase(input int quota);
		int stop_at;
		stop_at = sent + quota;
		while (sent < stop_at) begin
			case ($urandom_range(19))
				0, 1, 2, 3, 4, 5, 6: write_txn(pick_len());
				7, 8, 9, 10, 11, 12, 13: read_txn(pick_len(), 0);
				14, 15: broken_txn();
				16, 17: begin
					repeat ($urandom_range(4, 1))
						read_byte(7'($urandom));
				end
				default: begin
					// noise: stray loads, reads and events while idle
					repeat ($urandom_range(4, 1))
						case ($urandom_range(2))
							0: load_byte(7'($urandom), 8'($urandom));
							1: bus_event(any_status(), 8'($urandom));
							default: read_byte(7'($urandom));
						endcase
				end
			endcase
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part
		bus_event(with_low(StStart), 8'hFF);    // event while idle is ignored
		load_byte(7'd127, 8'hFF);
		load_byte(7'd1, 8'h00);
		load_byte(7'd2, 8'hA5);
		read_byte(7'd127);
		start_xfer(7'h7F, 1'b0, 7'd3);
		start_xfer(7'h00, 1'b1, 7'd127);        // start while busy is ignored
		bus_event(StStart | 8'h03, 8'h00);
		bus_event(StAddrWAck, 8'h5A);
		bus_event(StDataWAck, 8'h5A);
		bus_event(StDataWAck, 8'h5A);           // count reached: stop
		read_byte(7'd0);
		start_xfer(7'h00, 1'b1, 7'd0);          // receive with zero length
		bus_event(StAddrRAck, 8'h00);
		bus_event(StArbLost, 8'h00);
		bus_event(StDataRAck, 8'h3C);
		bus_event(StDataRNack, 8'h77);
		read_byte(7'd1);
		start_xfer(7'h55, 1'b1, 7'd4);
		bus_event(StRepStart, 8'h00);
		bus_event(StAddrRAck, 8'h00);
		bus_event(StDataRAck, 8'h11);
		bus_event(8'h00, 8'h00);                // fault with a zero status
		start_xfer(7'h01, 1'b0, 7'd1);
		bus_event(8'hFF, 8'hFF);
		bus_event(StDataWAck, 8'h00);           // ignored after the fault
		read_byte(7'd2);

		// Fill the whole buffer so every later read hits a written byte
		for (int i = 0; i < BufferDepthDefault; i++)
			load_byte(7'(i), 8'($urandom));
		run_phase(140);

		src_idle_pct = 45;
		sink_idle_pct = 16;
		run_phase(150);

		// No idling; receiver holds off while a long receive runs the pointer round
		src_idle_pct = 0;
		sink_idle_pct = 0;
		long_hold = 1'b1;
		read_txn(7'd5, 130);
		run_phase(150);

		s_tvalid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);

		$display("Run covered %0d command transfers and %0d checked result transfers,",
			sent, results_checked);
		$display("with %0d transactions closed by a stop and %0d ended by a bus fault.",
			clean_stops, faults_seen);
		if (fail_count == 0 && outstanding == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
